@@ hw/rtl/sbod_pkg.sv @@
// Package for the sieve bucket offset distributor.
// Holds the sizing constants, register indexes and the counter-chain request type.
// Used by sbod_cell and the top level in hw/rtl.
package sbod_pkg;

  localparam int FLAG_BITS    = 18;
  localparam int FLAG_SIZE    = 262144;
  localparam int MAX_BLOCKS   = 16;
  localparam int BKT_CAPACITY = 2048;

  localparam int BKT_W  = 4;
  localparam int SLOT_W = 11;
  localparam int CNT_W  = $clog2(BKT_CAPACITY) + 1;
  localparam int NB_W   = 5;
  localparam int LINE_W = NB_W + FLAG_BITS;

  localparam logic [1:0] REG_RESIDUE_DIFF    = 2'd0;
  localparam logic [1:0] REG_NUM_BLOCKS      = 2'd1;
  localparam logic [1:0] REG_LARGE_THRESHOLD = 2'd2;

  // Request that travels down the bucket counter chain
  typedef struct packed {
    logic              vld;
    logic              clr;
    logic              hit;
    logic              big;
    logic [BKT_W-1:0]  bucket;
    logic [SLOT_W-1:0] slot;
    logic              ovf;
  } chain_req_t;

endpackage

@@ hw/rtl/sbod_mod.sv @@
// Radix-2 restoring remainder unit: 64-bit dividend mod 32-bit divisor.
// One dividend bit per cycle. Depends on nothing but itself.
module sbod_mod (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] rem
);

  logic [63:0] dvd_r;
  logic [31:0] dvs_r;
  logic [32:0] rem_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [32:0] shifted;
  logic [32:0] rem_nxt;

  // One restoring step
  always_comb begin
    shifted = {rem_r[31:0], dvd_r[63]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = shifted - {1'b0, dvs_r};
    end else begin
      rem_nxt = shifted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[62:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r[31:0];

endmodule

@@ hw/rtl/sbod_cell.sv @@
// One bucket cell: normal and large counters for one bucket.
// Passes the chain request to its neighbor each cycle. Uses sbod_pkg.
module sbod_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [sbod_pkg::BKT_W-1:0] cell_idx,
  input  sbod_pkg::chain_req_t    req_in,
  output sbod_pkg::chain_req_t    req_out
);
  import sbod_pkg::*;

  logic [CNT_W-1:0] ncnt_r, ncnt_nxt;
  logic [CNT_W-1:0] lcnt_r, lcnt_nxt;
  chain_req_t       req_r, req_nxt;
  logic [CNT_W-1:0] cur;
  logic [CNT_W-1:0] upd;

  always_comb begin
    ncnt_nxt = ncnt_r;
    lcnt_nxt = lcnt_r;
    req_nxt  = req_in;
    cur      = '0;
    upd      = '0;
    if (req_in.vld) begin
      // line start clears both sets as the request passes
      if (req_in.clr) begin
        ncnt_nxt = '0;
        lcnt_nxt = '0;
      end
      if (req_in.hit && req_in.bucket == cell_idx) begin
        cur = req_in.big ? lcnt_nxt : ncnt_nxt;
        if (cur >= CNT_W'(BKT_CAPACITY)) begin
          upd         = CNT_W'(BKT_CAPACITY);
          req_nxt.ovf = 1'b1;
          req_nxt.slot = '0;
        end else begin
          upd          = cur + CNT_W'(1);
          req_nxt.slot = cur[SLOT_W-1:0];
        end
        if (req_in.big) begin
          lcnt_nxt = upd;
        end else begin
          ncnt_nxt = upd;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ncnt_r <= '0;
      lcnt_r <= '0;
      req_r  <= '0;
    end else begin
      ncnt_r <= ncnt_nxt;
      lcnt_r <= lcnt_nxt;
      req_r  <= req_nxt;
    end
  end

  assign req_out = req_r;

endmodule

@@ hw/rtl/sieve_bucket_offset_distributor_top.sv @@
// Sieve bucket offset distributor, top level. Uses sbod_pkg, sbod_mod, sbod_cell.
// Path from the accepting edge to out_valid: multiply, remainder start, 64
// bit-serial remainder steps, offset capture, 16 bucket cells, chain capture
// and the output register. A new transaction is accepted only when idle, once the
// last result has been loaded into the output register, and a result still held
// there delays the next one. Reset (synchronous, active low) clears counters,
// large mode and configuration.
module sieve_bucket_offset_distributor_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_first_of_line,
  input  logic [31:0] in_prime,
  input  logic [31:0] in_inverse,
  input  logic [31:0] in_lower_mod,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_hit,
  output logic        out_large_res,
  output logic        out_overflow,
  output logic [3:0]  out_bucket,
  output logic [10:0] out_slot,
  output logic [63:0] out_entry_word
);
  import sbod_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_HIT   = 3'd3;
  localparam logic [2:0] S_CHAIN = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]      state_r;
  logic [31:0]     residue_diff_r;
  logic [NB_W-1:0] num_blocks_r;
  logic [31:0]     large_thr_r;
  logic            large_mode_r;
  logic            first_r;
  logic [31:0]     prime_r, inv_r, sum_r, offset_r;
  logic [63:0]     prod_r;
  logic            div_go_r;
  chain_req_t      res_r;
  logic            div_done;
  logic [31:0]     div_rem;
  logic            in_acc;
  logic            mode_base;
  logic [NB_W-1:0] nb_sat;
  logic [LINE_W-1:0] line_size;
  logic            hit;
  chain_req_t      links [0:MAX_BLOCKS];
  logic            ovalid_r, ohit_r, olarge_r, oovf_r;
  logic [3:0]      obkt_r;
  logic [10:0]     oslot_r;
  logic [63:0]     oword_r;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign mode_base = in_first_of_line ? 1'b0 : large_mode_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      residue_diff_r <= '0;
      num_blocks_r   <= NB_W'(1);
      large_thr_r    <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESIDUE_DIFF:    residue_diff_r <= cfg_data;
        REG_NUM_BLOCKS:      num_blocks_r   <= cfg_data[NB_W-1:0];
        REG_LARGE_THRESHOLD: large_thr_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hit check on the finished offset: prime not zero, offset within the line size
  always_comb begin
    nb_sat    = (num_blocks_r > NB_W'(MAX_BLOCKS)) ? NB_W'(MAX_BLOCKS) : num_blocks_r;
    line_size = {nb_sat, {FLAG_BITS{1'b0}}};
    hit = (prime_r != 32'd0) && ({1'b0, offset_r} < {{(33-LINE_W){1'b0}}, line_size})
          && (offset_r[31:FLAG_BITS] < (32-FLAG_BITS)'(MAX_BLOCKS));
  end

  // Request injected into the cell chain
  always_comb begin
    links[0]        = '0;
    links[0].vld    = (state_r == S_HIT);
    links[0].clr    = first_r;
    links[0].hit    = hit;
    links[0].big    = large_mode_r;
    links[0].bucket = offset_r[FLAG_BITS +: BKT_W];
  end

  for (genvar gi = 0; gi < MAX_BLOCKS; gi++) begin : g_cell
    sbod_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .cell_idx(BKT_W'(gi)),
      .req_in  (links[gi]),
      .req_out (links[gi+1])
    );
  end

  sbod_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_go_r),
    .dividend(prod_r),
    .divisor (prime_r),
    .done    (div_done),
    .rem     (div_rem)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      large_mode_r <= 1'b0;
      div_go_r     <= 1'b0;
      ovalid_r     <= 1'b0;
    end else begin
      div_go_r <= 1'b0;
      // output register: load a new result or drop the one taken
      if (state_r == S_OUT && (!ovalid_r || out_ready)) begin
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            large_mode_r <= mode_base | (in_prime > large_thr_r);
            state_r      <= S_MUL;
          end
        end
        S_MUL: begin
          div_go_r <= 1'b1;
          state_r  <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= S_HIT;
          end
        end
        S_HIT: state_r <= S_CHAIN;
        S_CHAIN: begin
          if (links[MAX_BLOCKS].vld) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_r <= in_first_of_line;
      prime_r <= in_prime;
      inv_r   <= in_inverse;
      sum_r   <= in_lower_mod + residue_diff_r;
    end
    if (state_r == S_MUL) begin
      prod_r <= inv_r * sum_r;
    end
    if (state_r == S_DIV && div_done) begin
      offset_r <= div_rem;
    end
    if (state_r == S_CHAIN && links[MAX_BLOCKS].vld) begin
      res_r <= links[MAX_BLOCKS];
    end
    if (state_r == S_OUT && (!ovalid_r || out_ready)) begin
      ohit_r   <= res_r.hit;
      olarge_r <= res_r.big;
      oovf_r   <= res_r.hit & res_r.ovf;
      obkt_r   <= res_r.hit ? res_r.bucket : 4'd0;
      oslot_r  <= (res_r.hit && !res_r.ovf) ? res_r.slot : 11'd0;
      if (!res_r.hit || res_r.ovf) begin
        oword_r <= '0;
      end else if (res_r.big) begin
        oword_r <= {32'd0, offset_r};
      end else begin
        oword_r <= {prime_r, offset_r};
      end
    end
  end

  assign out_valid      = ovalid_r;
  assign out_hit        = ohit_r;
  assign out_large_res  = olarge_r;
  assign out_overflow   = oovf_r;
  assign out_bucket     = obkt_r;
  assign out_slot       = oslot_r;
  assign out_entry_word = oword_r;

  // Checks
  a_chain_only_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    links[MAX_BLOCKS].vld |-> state_r == S_CHAIN) else $error("chain result out of turn");
  a_ovf_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overflow |-> out_hit && out_slot == 11'd0 && out_entry_word == 64'd0)
    else $error("overflow result not cleared");
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready) else $error("accepted while busy");
  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_go_r |-> state_r == S_DIV) else $error("remainder unit started out of turn");

endmodule

@@ tb/sv/sbod_scoreboard.sv @@
// Checker for the sieve bucket offset distributor: tracks config writes, predicts
// each result from accepted input transactions and compares output transactions.
// Depends on sbod_pkg for register indexes and sizing constants.
module sbod_scoreboard (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_first_of_line,
  input  logic [31:0] in_prime,
  input  logic [31:0] in_inverse,
  input  logic [31:0] in_lower_mod,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_hit,
  input  logic        out_large_res,
  input  logic        out_overflow,
  input  logic [3:0]  out_bucket,
  input  logic [10:0] out_slot,
  input  logic [63:0] out_entry_word,
  output int          err_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import sbod_pkg::*;

  typedef struct packed {
    logic              hit;
    logic              big;
    logic              ovf;
    logic [BKT_W-1:0]  bucket;
    logic [SLOT_W-1:0] slot;
    logic [63:0]       word;
  } placement_t;

  placement_t placement_q[$];

  // shadow configuration and counter state
  logic [31:0]      residue_diff;
  logic [NB_W-1:0]  num_blocks;
  logic [31:0]      large_threshold;
  logic [CNT_W-1:0] norm_cnt[MAX_BLOCKS];
  logic [CNT_W-1:0] big_cnt[MAX_BLOCKS];
  logic             large_mode;
  int               errs = 0;

  assign pending   = placement_q.size();
  assign err_count = errs;

  task automatic report(input string field, input logic [63:0] got, input logic [63:0] want);
    $display("[%0t] mismatch on %0s: got %h, expected %h", $realtime, field, got, want);
    errs++;
  endtask

  // Work out the placement of one prime and advance the counters
  function automatic placement_t place_prime(input logic first, input logic [31:0] prime,
                                             input logic [31:0] inv, input logic [31:0] lmod);
    placement_t       p;
    logic [31:0]      sum;
    logic [63:0]      offset;
    logic [63:0]      line_len;
    logic [NB_W-1:0]  nb;
    logic [63:0]      bnum;
    logic [BKT_W-1:0] bidx;
    logic [CNT_W-1:0] cnt;
    p = '0;
    if (first) begin
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        norm_cnt[k] = '0;
        big_cnt[k]  = '0;
      end
      large_mode = 1'b0;
    end
    if (prime > large_threshold) large_mode = 1'b1;
    p.big = large_mode;
    if (prime == 32'd0) return p;
    sum      = lmod + residue_diff;
    offset   = ({32'd0, inv} * {32'd0, sum}) % {32'd0, prime};
    nb       = (num_blocks > MAX_BLOCKS) ? NB_W'(MAX_BLOCKS) : num_blocks;
    line_len = 64'(nb) * 64'(FLAG_SIZE);
    if (offset >= line_len) return p;
    bnum = offset >> FLAG_BITS;
    if (bnum >= MAX_BLOCKS) return p;
    bidx     = bnum[BKT_W-1:0];
    cnt      = large_mode ? big_cnt[bidx] : norm_cnt[bidx];
    p.hit    = 1'b1;
    p.bucket = bidx;
    if (cnt >= BKT_CAPACITY) begin
      cnt   = CNT_W'(BKT_CAPACITY);
      p.ovf = 1'b1;
    end else begin
      p.slot = cnt[SLOT_W-1:0];
      p.word = large_mode ? offset : {prime, offset[31:0]};
      cnt    = cnt + 1'b1;
    end
    if (large_mode) big_cnt[bidx] = cnt;
    else norm_cnt[bidx] = cnt;
    return p;
  endfunction

  // Watch config, input and output transactions
  always @(posedge clk) begin
    placement_t want;
    if (!rst_n) begin
      residue_diff    <= '0;
      num_blocks      <= NB_W'(1);
      large_threshold <= 32'hFFFF_FFFF;
      large_mode      <= 1'b0;
      for (int k = 0; k < MAX_BLOCKS; k++) begin
        norm_cnt[k] <= '0;
        big_cnt[k]  <= '0;
      end
      placement_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RESIDUE_DIFF:    residue_diff    <= cfg_data;
          REG_NUM_BLOCKS:      num_blocks      <= cfg_data[NB_W-1:0];
          REG_LARGE_THRESHOLD: large_threshold <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        placement_q.push_back(place_prime(in_first_of_line, in_prime, in_inverse,
                                          in_lower_mod));
      if (out_valid && out_ready) begin
        if (placement_q.size() == 0) begin
          report("unexpected transaction", out_entry_word, 64'd0);
        end else begin
          want = placement_q.pop_front();
          if (out_hit != want.hit) report("hit", 64'(out_hit), 64'(want.hit));
          if (out_large_res != want.big)
            report("large_res", 64'(out_large_res), 64'(want.big));
          if (out_overflow != want.ovf)
            report("overflow", 64'(out_overflow), 64'(want.ovf));
          if (out_bucket != want.bucket)
            report("bucket", 64'(out_bucket), 64'(want.bucket));
          if (out_slot != want.slot) report("slot", 64'(out_slot), 64'(want.slot));
          if (out_entry_word != want.word) report("entry_word", out_entry_word, want.word);
        end
      end
    end
  end

endmodule

@@ tb/sv/tb_sieve_bucket_offset_distributor_top.sv @@
// Testbench top for the sieve bucket offset distributor: clock, reset, config
// writes and prime stimulus with random stalls. Uses sbod_pkg and sbod_scoreboard.
module tb_sieve_bucket_offset_distributor_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sbod_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_first_of_line;
  logic [31:0] in_prime;
  logic [31:0] in_inverse;
  logic [31:0] in_lower_mod;
  logic        out_valid;
  logic        out_ready;
  logic        out_hit;
  logic        out_large_res;
  logic        out_overflow;
  logic [3:0]  out_bucket;
  logic [10:0] out_slot;
  logic [63:0] out_entry_word;
  int          err_count;
  int          pending;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          quiet_cycles = 0;

  sieve_bucket_offset_distributor_top dut (.*);
  sbod_scoreboard u_scoreboard (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver backpressure
  always @(posedge clk) out_ready <= ($urandom_range(99) >= rx_idle_pct);

  // Watchdog on cycles with no transaction at all
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_sieve_bucket_offset_distributor_top: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_cfg(input logic [31:0] rdiff, input logic [31:0] nblk,
                           input logic [31:0] thresh);
    cfg_we    <= 1'b1;
    cfg_index <= REG_RESIDUE_DIFF;
    cfg_data  <= rdiff;
    @(posedge clk);
    cfg_index <= REG_NUM_BLOCKS;
    cfg_data  <= nblk;
    @(posedge clk);
    cfg_index <= REG_LARGE_THRESHOLD;
    cfg_data  <= thresh;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every predicted placement has come back, then let the pipe settle
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic send_prime(input logic first, input logic [31:0] prime,
                            input logic [31:0] inv, input logic [31:0] lmod);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_first_of_line <= first;
    in_prime         <= prime;
    in_inverse       <= inv;
    in_lower_mod     <= lmod;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_prime();
    logic [31:0] prime;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 65) prime = $urandom_range(2, 4_500_000);
    else if (pick < 80) prime = $urandom_range(2, 300);
    else if (pick < 95) prime = $urandom;
    else if (pick < 97) prime = 32'd0;
    else prime = 32'hFFFF_FFFF - $urandom_range(0, 16);
    send_prime($urandom_range(11) == 0, prime, $urandom, $urandom);
  endtask

  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_RESIDUE_DIFF;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_first_of_line = 1'b0;
    in_prime         = '0;
    in_inverse       = '0;
    in_lower_mod     = '0;
    tx_idle_pct      = 0;
    rx_idle_pct      = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset config, field extremes, prime zero, big primes
    send_prime(1'b1, 32'd7, 32'd3, 32'd5);
    send_prime(1'b0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_prime(1'b0, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_prime(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFE);
    send_prime(1'b0, 32'hFFFF_FFFB, 32'd1, 32'd100);
    send_prime(1'b0, 32'd11, 32'd0, 32'd0);
    in_valid <= 1'b0;
    drain();

    // Directed: threshold crossing turns large mode on until the next line start
    write_cfg(32'hFFFF_FFFF, 32'd16, 32'd1000);
    send_prime(1'b0, 32'd997, 32'd5, 32'd9);
    send_prime(1'b0, 32'd1009, 32'd7, 32'd12);
    send_prime(1'b0, 32'd3, 32'd2, 32'd1);
    send_prime(1'b0, 32'd0, 32'd2, 32'd1);
    send_prime(1'b1, 32'd5, 32'd4, 32'd2);
    send_prime(1'b1, 32'd0, 32'd1, 32'd1);
    in_valid <= 1'b0;
    drain();

    // Directed: empty line, then oversized block count hitting the last bucket
    write_cfg(32'd0, 32'd0, 32'hFFFF_FFFF);
    send_prime(1'b1, 32'd4194301, 32'd1, 32'd4194300);
    send_prime(1'b0, 32'd13, 32'd1, 32'd2);
    in_valid <= 1'b0;
    drain();
    write_cfg(32'd0, 32'd31, 32'd0);
    send_prime(1'b0, 32'd4194301, 32'd1, 32'd4194300);
    send_prime(1'b0, 32'd4194301, 32'd1, 32'd262144);
    send_prime(1'b1, 32'd1, 32'd1, 32'd0);
    in_valid <= 1'b0;
    drain();

    // Bucket fill: one block, small primes always hit bucket zero and climb its slots
    write_cfg(32'd0, 32'd1, 32'hFFFF_FFFF);
    send_prime(1'b1, 32'd3, 32'd1, 32'd1);
    repeat (600) send_prime(1'b0, $urandom_range(2, 262143), $urandom, $urandom);
    in_valid <= 1'b0;
    drain();

    // Random lines across several configurations and stall patterns
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_cfg(32'd0, 32'd1, 32'hFFFF_FFFF);
        1: write_cfg(32'hFFFF_FFFF, 32'd16, $urandom_range(100_000, 3_000_000));
        2: write_cfg($urandom, 32'd31, $urandom_range(50_000, 2_000_000));
        3: write_cfg($urandom, 32'd0, $urandom);
        4: write_cfg($urandom, $urandom_range(1, 16), 32'd0);
        default: write_cfg($urandom, $urandom_range(0, 31), $urandom_range(1000, 4_000_000));
      endcase
      tx_idle_pct = (phase < 2) ? 26 : (phase < 4) ? 70 : 0;
      rx_idle_pct = (phase < 2) ? 70 : (phase < 4) ? 26 : 0;
      send_prime(1'b1, $urandom_range(2, 1000), $urandom, $urandom);
      for (int n = 0; n < 115; n++) begin
        // sender holds off until the pipe is empty
        if (phase == 2 && n == 100) begin
          in_valid <= 1'b0;
          while (pending != 0) @(posedge clk);
        end
        send_random_prime();
      end
      in_valid <= 1'b0;
      drain();
    end

    if (err_count == 0 && pending == 0) begin
      $display("tb_sieve_bucket_offset_distributor_top: clean");
    end else begin
      $display("tb_sieve_bucket_offset_distributor_top: errors");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hw/rtl/sbod_pkg.sv
hw/rtl/sbod_mod.sv
hw/rtl/sbod_cell.sv
hw/rtl/sieve_bucket_offset_distributor_top.sv
tb/sv/sbod_scoreboard.sv
tb/sv/tb_sieve_bucket_offset_distributor_top.sv
